// ===== design/sha1md_pkg.sv =====
// SHA-1 digest core package: payload structs, queue entry, sequencer states,
// compression control struct and the SHA-1 constants.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package sha1md_pkg;

	typedef logic [31:0] sha1md_word_t;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       byte_valid;
		logic       end_of_message;
	} sha1md_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha1md_out_t;

	// Classified input transaction; items with neither byte nor end mark are dropped.
	typedef enum logic [1:0] {
		OP_BYTE,
		OP_BYTE_END,
		OP_END
	} sha1md_op_e;

	typedef struct packed {
		sha1md_op_e op;
		logic [7:0] data;
	} sha1md_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_PAD,
		ST_LEN,
		ST_WAIT,
		ST_EMIT
	} sha1md_state_e;

	typedef struct packed {
		logic start;
		logic reload;
	} sha1md_cmp_ctl_t;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [6:0] ROUND_LAST  = 7'd79;
	localparam logic [6:0] ROUND_FINAL = 7'd80;

	localparam logic [5:0] PAD_END     = 6'd56;
	localparam logic [5:0] POS_LAST    = 6'd63;
	localparam logic [2:0] LEN_LAST    = 3'd7;
	localparam logic [2:0] WORD_LAST   = 3'd4;
	localparam logic [7:0] PAD_MARK    = 8'h80;

	localparam sha1md_word_t K0 = 32'h5A827999;
	localparam sha1md_word_t K1 = 32'h6ED9EBA1;
	localparam sha1md_word_t K2 = 32'h8F1BBCDC;
	localparam sha1md_word_t K3 = 32'hCA62C1D6;

	localparam sha1md_word_t IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

endpackage

// ===== design/sha1md_fifo.sv =====
// Short transaction queue between the front and back of the SHA-1 core.
// Depends on sha1md_pkg for the queue entry type.
`timescale 1ns / 1ps

module sha1md_fifo import sha1md_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sha1md_entry_t push_data,
	output logic          full,
	input  logic          pop,
	output sha1md_entry_t pop_data,
	output logic          nonempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sha1md_entry_t   mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/sha1md_front.sv =====
// Input side of the SHA-1 core: accepts message transactions, classifies
// them and forwards non-empty ones to the queue. Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_front import sha1md_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_stall,
	input  sha1md_in_t    msg,
	output logic          push,
	output sha1md_entry_t push_data,
	input  logic          full
);

	logic          ent_valid_q;
	sha1md_entry_t ent_q;
	logic          accept;
	logic          keep;
	sha1md_entry_t cls;

	assign msg_stall = ent_valid_q && full;
	assign accept    = msg_valid && !msg_stall;
	assign push      = ent_valid_q;
	assign push_data = ent_q;

	always_comb begin
		cls.data = msg.message_byte;
		if (msg.byte_valid && msg.end_of_message) begin
			cls.op = OP_BYTE_END;
		end else if (msg.byte_valid) begin
			cls.op = OP_BYTE;
		end else begin
			cls.op = OP_END;
		end
	end

	// drop items that carry neither a byte nor an end mark
	assign keep = accept && (msg.byte_valid || msg.end_of_message);

	always_ff @(posedge clk) begin
		if (keep) begin
			ent_q <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
		end else begin
			ent_valid_q <= keep || (ent_valid_q && full);
		end
	end

endmodule

// ===== design/sha1md_compress.sv =====
// SHA-1 compression unit: one round per cycle over a 16-word schedule window,
// then a final add into the chaining words. Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_compress import sha1md_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  sha1md_cmp_ctl_t ctl,
	input  sha1md_word_t    blk [16],
	output logic            busy,
	output sha1md_word_t    h [5]
);

	logic         busy_q;
	logic [6:0]   round_q;
	sha1md_word_t h_q [5];
	sha1md_word_t a_q, b_q, c_q, d_q, e_q;
	sha1md_word_t w_q [16];
	sha1md_word_t f;
	sha1md_word_t k;
	sha1md_word_t t;
	sha1md_word_t w_mix;
	sha1md_word_t w_next;

	assign busy = busy_q;

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			h[i] = h_q[i];
		end
	end

	always_comb begin
		case (round_q) inside
			[7'd0:7'd19]: begin
				f = (b_q & c_q) | (~b_q & d_q);
				k = K0;
			end
			[7'd20:7'd39]: begin
				f = b_q ^ c_q ^ d_q;
				k = K1;
			end
			[7'd40:7'd59]: begin
				f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k = K2;
			end
			default: begin
				f = b_q ^ c_q ^ d_q;
				k = K3;
			end
		endcase
	end

	assign t      = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
	assign w_mix  = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_next = {w_mix[30:0], w_mix[31]};

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk[i];
			end
		end else if (busy_q && round_q != ROUND_FINAL) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			// slide the schedule window by one word
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= IV[i];
			end
		end else if (ctl.reload) begin
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= IV[i];
			end
		end else if (ctl.start) begin
			busy_q  <= 1'b1;
			round_q <= '0;
		end else if (busy_q) begin
			if (round_q == ROUND_FINAL) begin
				busy_q <= 1'b0;
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end else begin
				round_q <= round_q + 7'd1;
			end
		end
	end

endmodule

// ===== design/sha1md_back.sv =====
// Back end of the SHA-1 core: packs bytes into the block buffer, pads the
// message, drives the compression unit and emits the digest words.
// Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_back import sha1md_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  sha1md_entry_t   q_entry,
	output logic            pop,
	output sha1md_cmp_ctl_t ctl,
	output sha1md_word_t    blk [16],
	input  logic            busy,
	input  sha1md_word_t    h [5],
	output logic            dig_valid,
	input  logic            dig_stall,
	output sha1md_out_t     dig
);

	sha1md_state_e state_q;
	sha1md_state_e next_state;
	logic [5:0]    pos_q;
	logic [60:0]   count_q;
	logic [2:0]    len_idx_q;
	logic [2:0]    word_idx_q;
	sha1md_word_t  blk_q [16];
	logic          full_q;
	logic          out_valid_q;
	sha1md_out_t   out_q;

	logic          out_free;
	logic          wr_en;
	logic [7:0]    wr_byte;
	logic          count_en;
	logic          emit;
	logic          reload;
	logic [63:0]   total;
	logic [5:0]    len_shift;
	logic [7:0]    len_byte;

	assign out_free  = !out_valid_q || !dig_stall;
	assign dig_valid = out_valid_q;
	assign dig       = out_q;

	assign total     = {count_q, 3'b000};
	assign len_shift = {~len_idx_q, 3'b000};
	assign len_byte  = 8'(total >> len_shift);

	assign ctl.start  = full_q && !busy;
	assign ctl.reload = reload;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			blk[i] = blk_q[i];
		end
	end

	always_comb begin
		next_state = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && !full_q) begin
					next_state = (q_entry.op == OP_BYTE) ? ST_IDLE : ST_MARK;
				end
			end
			ST_MARK: begin
				if (!full_q) begin
					next_state = ST_PAD;
				end
			end
			ST_PAD: begin
				if (pos_q == PAD_END) begin
					next_state = ST_LEN;
				end
			end
			ST_LEN: begin
				if (!full_q && len_idx_q == LEN_LAST) begin
					next_state = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!full_q && !busy) begin
					next_state = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && word_idx_q == WORD_LAST) begin
					next_state = ST_IDLE;
				end
			end
			default: begin
				next_state = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		wr_en    = 1'b0;
		wr_byte  = q_entry.data;
		count_en = 1'b0;
		emit     = 1'b0;
		reload   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && !full_q) begin
					pop = 1'b1;
					if (q_entry.op != OP_END) begin
						wr_en    = 1'b1;
						count_en = 1'b1;
					end
				end
			end
			ST_MARK: begin
				wr_en   = !full_q;
				wr_byte = PAD_MARK;
			end
			ST_PAD: begin
				wr_en   = !full_q && pos_q != PAD_END;
				wr_byte = '0;
			end
			ST_LEN: begin
				wr_en   = !full_q;
				wr_byte = len_byte;
			end
			ST_WAIT: begin
			end
			ST_EMIT: begin
				emit   = out_free;
				reload = out_free && word_idx_q == WORD_LAST;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= wr_byte;
		end
		if (emit) begin
			out_q.digest_word <= h[word_idx_q];
			out_q.word_index  <= word_idx_q;
			out_q.last_word   <= (word_idx_q == WORD_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			count_q     <= '0;
			len_idx_q   <= '0;
			word_idx_q  <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= next_state;
			if (wr_en) begin
				pos_q <= pos_q + 6'd1;
			end
			// hold further writes until the compression unit takes the block
			if (wr_en && pos_q == POS_LAST) begin
				full_q <= 1'b1;
			end else if (ctl.start) begin
				full_q <= 1'b0;
			end
			if (reload) begin
				count_q <= '0;
			end else if (count_en) begin
				count_q <= count_q + 61'd1;
			end
			if (wr_en && state_q == ST_LEN) begin
				len_idx_q <= len_idx_q + 3'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				word_idx_q  <= (word_idx_q == WORD_LAST) ? '0 : word_idx_q + 3'd1;
			end else if (!dig_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// between messages the fill position follows the byte count
	a_pos_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> pos_q == count_q[5:0])
		else $error("fill position out of step with byte count");

	// the digest is read only once the last block is fully folded in
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !busy && !full_q)
		else $error("digest emitted while compression pending");

	// a block is never overwritten while it waits for the compression unit
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && !ctl.start |=> full_q || $past(ctl.start))
		else $error("pending block released without compression start");

	a_len_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LEN |-> pos_q[5:3] == 3'b111 && pos_q[2:0] == len_idx_q)
		else $error("length bytes misplaced in final block");

endmodule

// ===== design/sha1_message_digest_core.sv =====
// SHA-1 message digest core.
// Input channel msg (msg_valid/msg_stall): one transaction per item carrying
// an optional message byte (byte_valid) and an end-of-message mark. Items with
// neither are accepted and dropped. An item with the end mark and no byte asks
// for the digest of the bytes sent so far (the empty digest if none).
// Output channel dig (dig_valid/dig_stall): five transactions per message,
// digest words 0..4, most significant first, last_word set on word 4.
// Throughput: each full 64-byte block goes through the compression unit
// (start, 80 rounds, final add) while the next block is loaded, so long
// messages are limited by the one-round-per-cycle compression unit.
// After the end item come the padding bytes and the length, waits for the
// compression unit, then one or two block compressions, then the five
// digest words in order.
// Reset loads the standard initial chaining values, clears the bit count and
// empties the queue. A stall on dig holds the output register; the digest
// sequencer then waits, the queue fills and msg_stall rises.
// Depends on sha1md_pkg, sha1md_front, sha1md_fifo, sha1md_back, sha1md_compress.
`timescale 1ns / 1ps

module sha1_message_digest_core import sha1md_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  sha1md_in_t  msg,
	output logic        dig_valid,
	input  logic        dig_stall,
	output sha1md_out_t dig
);

	logic            push;
	sha1md_entry_t   push_data;
	logic            full;
	logic            pop;
	sha1md_entry_t   q_entry;
	logic            q_valid;
	sha1md_cmp_ctl_t ctl;
	sha1md_word_t    blk [16];
	logic            busy;
	sha1md_word_t    h [5];

	sha1md_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	sha1md_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (q_entry),
		.nonempty  (q_valid)
	);

	sha1md_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.pop       (pop),
		.ctl       (ctl),
		.blk       (blk),
		.busy      (busy),
		.h         (h),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	sha1md_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.blk    (blk),
		.busy   (busy),
		.h      (h)
	);

endmodule
